/* hw/rtl/assert_macros.svh */
// assertion macros used by the top level rtl file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is low
`define TTD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define TTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ttd_pkg.sv */
// shared types and constants of the touch trend detector
// used by the channel interfaces, the lanes, the merge stage and the top level
package ttd_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_W    = 16;
  localparam int IMP_W       = SAMPLE_W + 1;
  localparam int THR_W       = 5;
  localparam int BAR_W       = 16;
  localparam int MASK_W      = 4;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int HISTORY_DEF = 32;
  localparam int WINDOW_DEF  = 17;

  // register reset values
  localparam logic [THR_W-1:0] THR_RST  = THR_W'(7);
  localparam logic [BAR_W-1:0] BAR1_RST = BAR_W'(3);
  localparam logic [BAR_W-1:0] BAR2_RST = BAR_W'(3);
  localparam logic [BAR_W-1:0] DROP_RST = BAR_W'(2);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INC_THR  = CFG_IDX_W'(0),
    REG_BAR_ONE  = CFG_IDX_W'(1),
    REG_BAR_TWO  = CFG_IDX_W'(2),
    REG_DROP_LIM = CFG_IDX_W'(3)
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] inc_thr;
    logic [BAR_W-1:0] bar_one;
    logic [BAR_W-1:0] bar_two;
    logic [BAR_W-1:0] drop_lim;
  } cfg_t;

  // lane control from the top level
  typedef struct packed {
    logic shift_en;
    logic cap_en;
  } lane_ctl_t;

  // merge stage control from the top level
  typedef struct packed {
    logic adv;
    logic item_vld;
    logic armed;
  } merge_ctl_t;

endpackage

/* hw/rtl/ttd_if.sv */
// channel interfaces: input words, result words and configuration writes
// depends on ttd_pkg
interface ttd_in_if;
  logic                          valid;
  logic                          ready;
  logic [ttd_pkg::SAMPLE_W-1:0]  sample_ch0;
  logic [ttd_pkg::SAMPLE_W-1:0]  sample_ch1;
  logic [ttd_pkg::SAMPLE_W-1:0]  sample_ch2;
  logic [ttd_pkg::SAMPLE_W-1:0]  sample_ch3;
  logic                          armed;

  modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, armed,
                  input ready);
  modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, armed,
                output ready);
endinterface

interface ttd_out_if;
  logic                        valid;
  logic                        ready;
  logic [ttd_pkg::MASK_W-1:0]  pass_mask;
  logic [ttd_pkg::MASK_W-1:0]  touch_event_mask;
  logic [ttd_pkg::MASK_W-1:0]  touched_marks;
  logic                        any_touched;

  modport source (output valid, pass_mask, touch_event_mask, touched_marks, any_touched,
                  input ready);
  modport sink (input valid, pass_mask, touch_event_mask, touched_marks, any_touched,
                output ready);
endinterface

interface ttd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ttd_pkg::CFG_IDX_W-1:0]   index;
  logic [ttd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/ttd_lane.sv */
// one channel lane: sample shift line and per-step window comparators
// depends on ttd_pkg
module ttd_lane #(
  parameter int HISTORY = ttd_pkg::HISTORY_DEF,
  parameter int WINDOW  = ttd_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ttd_pkg::lane_ctl_t                  ctl,
  input  logic [ttd_pkg::SAMPLE_W-1:0]        sample,
  input  logic [ttd_pkg::BAR_W-1:0]           drop_lim,
  output logic [WINDOW-1:0]                   fall_r,
  output logic                                veto_r,
  output logic signed [ttd_pkg::IMP_W-1:0]    impulse_r
);

  logic [ttd_pkg::SAMPLE_W-1:0]      hist_r [HISTORY];
  logic [WINDOW-1:0]                 fall_nxt;
  logic [WINDOW-1:0]                 rise_vec;
  logic                              veto_nxt;
  logic signed [ttd_pkg::IMP_W-1:0]  impulse_nxt;

  // history shift line, slot 0 holds the newest sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY; i++) begin
        hist_r[i] <= '0;
      end
    end else if (ctl.shift_en) begin
      hist_r[0] <= sample;
      for (int i = 1; i < HISTORY; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // one comparator pair per window step, slots wrap around the history
  for (genvar s = 0; s < WINDOW; s++) begin : g_step
    localparam int NEW_IDX = s % HISTORY;
    localparam int OLD_IDX = (s + 1) % HISTORY;
    assign fall_nxt[s] = hist_r[OLD_IDX] > hist_r[NEW_IDX];
    assign rise_vec[s] = {1'b0, hist_r[NEW_IDX]} >
                         ({1'b0, hist_r[OLD_IDX]} + {1'b0, drop_lim});
  end

  // veto on any large rise, impulse is oldest minus newest
  assign veto_nxt    = |rise_vec;
  assign impulse_nxt = signed'({1'b0, hist_r[HISTORY-1]}) - signed'({1'b0, hist_r[0]});

  // step flags, veto and impulse register
  always_ff @(posedge clk) begin
    if (ctl.cap_en) begin
      fall_r    <= fall_nxt;
      veto_r    <= veto_nxt;
      impulse_r <= impulse_nxt;
    end
  end

endmodule

/* hw/rtl/ttd_merge.sv */
// merge stage: per-channel judgement, touch marks and result register
// depends on ttd_pkg and ttd_if
module ttd_merge #(
  parameter int WINDOW = ttd_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ttd_pkg::merge_ctl_t               ctl,
  input  ttd_pkg::cfg_t                     cfg,
  input  logic [WINDOW-1:0]                 fall [ttd_pkg::CHANNELS],
  input  logic [ttd_pkg::CHANNELS-1:0]      veto,
  input  logic signed [ttd_pkg::IMP_W-1:0]  impulse [ttd_pkg::CHANNELS],
  ttd_out_if.source                         out_ch
);

  localparam int CNT_BITS = $clog2(WINDOW + 1);
  localparam int JW = ((CNT_BITS > ttd_pkg::THR_W) ? CNT_BITS : ttd_pkg::THR_W) + 2;

  logic signed [JW-1:0]            thr_s;
  logic [ttd_pkg::CHANNELS-1:0]    pass_c;
  logic [ttd_pkg::CHANNELS-1:0]    evt_c;
  logic                            out_valid_r;
  logic [ttd_pkg::MASK_W-1:0]      pass_r;
  logic [ttd_pkg::MASK_W-1:0]      evt_r;
  logic [ttd_pkg::MASK_W-1:0]      marks_r;
  logic [ttd_pkg::MASK_W-1:0]      marks_nxt;

  assign thr_s = signed'({{(JW - ttd_pkg::THR_W){1'b0}}, cfg.inc_thr});

  // judge every channel from its step flags and impulse
  always_comb begin
    logic signed [JW-1:0]               cnt;
    logic signed [JW-1:0]               gap;
    logic [ttd_pkg::BAR_W-1:0]          bar;
    logic                               sure;
    logic                               near;
    logic                               beat;
    for (int c = 0; c < ttd_pkg::CHANNELS; c++) begin
      cnt  = veto[c] ? -JW'(1) : signed'(JW'($countones(fall[c])));
      gap  = thr_s - cnt;
      sure = cnt >= thr_s;
      near = (gap == JW'(1)) || (gap == JW'(2));
      bar  = (gap == JW'(1)) ? cfg.bar_one : cfg.bar_two;
      beat = signed'({2'b00, bar}) < signed'({impulse[c][ttd_pkg::IMP_W-1], impulse[c]});
      pass_c[c] = sure || (near && beat);
    end
  end

  assign evt_c     = ctl.armed ? pass_c : '0;
  assign marks_nxt = marks_r | evt_c[ttd_pkg::MASK_W-1:0];

  // result valid and sticky marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      marks_r     <= '0;
    end else if (ctl.adv) begin
      out_valid_r <= ctl.item_vld;
      if (ctl.item_vld) begin
        marks_r <= marks_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctl.adv && ctl.item_vld) begin
      pass_r <= pass_c[ttd_pkg::MASK_W-1:0];
      evt_r  <= evt_c[ttd_pkg::MASK_W-1:0];
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.pass_mask        = pass_r;
  assign out_ch.touch_event_mask = evt_r;
  assign out_ch.touched_marks    = marks_r;
  assign out_ch.any_touched      = |marks_r;

endmodule

/* hw/rtl/touch_trend_detector.sv */
// touch trend detector top level: configuration registers, lane control, lanes and merge
// depends on ttd_pkg, ttd_if, ttd_lane, ttd_merge and assert_macros.svh
`include "assert_macros.svh"

// Each accepted word shifts one sample per channel into that channel's history line; four
// lanes then compare every window step side by side and a merge stage counts falling steps,
// applies the rise veto and impulse bars and updates the sticky touch marks. The block takes
// one word per cycle as long as results are taken; the accepting edge shifts the samples in
// and each word's result then passes through the step flags register and the result register.
// The whole pipeline stalls while the result register is full and not taken. Configuration
// writes are accepted in every cycle.
module touch_trend_detector #(
  parameter int HISTORY = ttd_pkg::HISTORY_DEF,
  parameter int WINDOW  = ttd_pkg::WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ttd_in_if.sink     in_ch,
  ttd_out_if.source  out_ch,
  ttd_cfg_if.sink    cfg_ch
);

  ttd_pkg::cfg_t                     cfg_r;
  logic                              adv;
  logic                              in_fire;
  logic                              pend_r;
  logic                              pend_armed_r;
  logic                              v1_r;
  logic                              armed1_r;
  ttd_pkg::lane_ctl_t                lane_ctl;
  ttd_pkg::merge_ctl_t               merge_ctl;
  logic [ttd_pkg::SAMPLE_W-1:0]      samples [ttd_pkg::CHANNELS];
  logic [WINDOW-1:0]                 fall [ttd_pkg::CHANNELS];
  logic [ttd_pkg::CHANNELS-1:0]      veto;
  logic signed [ttd_pkg::IMP_W-1:0]  impulse [ttd_pkg::CHANNELS];

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inc_thr  <= ttd_pkg::THR_RST;
      cfg_r.bar_one  <= ttd_pkg::BAR1_RST;
      cfg_r.bar_two  <= ttd_pkg::BAR2_RST;
      cfg_r.drop_lim <= ttd_pkg::DROP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        ttd_pkg::REG_INC_THR:  cfg_r.inc_thr  <= cfg_ch.data[ttd_pkg::THR_W-1:0];
        ttd_pkg::REG_BAR_ONE:  cfg_r.bar_one  <= cfg_ch.data[ttd_pkg::BAR_W-1:0];
        ttd_pkg::REG_BAR_TWO:  cfg_r.bar_two  <= cfg_ch.data[ttd_pkg::BAR_W-1:0];
        ttd_pkg::REG_DROP_LIM: cfg_r.drop_lim <= cfg_ch.data[ttd_pkg::BAR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the result register can take a word
  assign adv          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = adv;
  assign in_fire      = in_ch.valid && adv;

  // stage valids: sample shifted, then step flags captured
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      v1_r   <= 1'b0;
    end else if (adv) begin
      pend_r <= in_fire;
      v1_r   <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pend_armed_r <= in_ch.armed;
      armed1_r     <= pend_armed_r;
    end
  end

  assign lane_ctl.shift_en = in_fire;
  assign lane_ctl.cap_en   = adv;

  assign merge_ctl.adv      = adv;
  assign merge_ctl.item_vld = v1_r;
  assign merge_ctl.armed    = armed1_r;

  assign samples[0] = in_ch.sample_ch0;
  assign samples[1] = in_ch.sample_ch1;
  assign samples[2] = in_ch.sample_ch2;
  assign samples[3] = in_ch.sample_ch3;

  // one lane per channel
  for (genvar c = 0; c < ttd_pkg::CHANNELS; c++) begin : g_lane
    ttd_lane #(
      .HISTORY (HISTORY),
      .WINDOW  (WINDOW)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (lane_ctl),
      .sample    (samples[c]),
      .drop_lim  (cfg_r.drop_lim),
      .fall_r    (fall[c]),
      .veto_r    (veto[c]),
      .impulse_r (impulse[c])
    );
  end

  // judgement and result register
  ttd_merge #(
    .WINDOW (WINDOW)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (merge_ctl),
    .cfg     (cfg_r),
    .fall    (fall),
    .veto    (veto),
    .impulse (impulse),
    .out_ch  (out_ch)
  );

  // touch marks only ever gain bits outside reset
  `TTD_ASSERT(a_marks_sticky, clk, rst_n, $past(rst_n) |-> ((out_ch.touched_marks & $past(out_ch.touched_marks)) == $past(out_ch.touched_marks)), "touch mark lost")

  // events are a subset of passes and are already marked
  `TTD_ASSERT(a_event_subset, clk, rst_n, out_ch.valid |-> (((out_ch.touch_event_mask & ~out_ch.pass_mask) == '0) && ((out_ch.touch_event_mask & ~out_ch.touched_marks) == '0)), "event mask inconsistent")

  // no word taken while the result register is stalled
  `TTD_ASSERT(a_stall_blocks_in, clk, rst_n, (out_ch.valid && !out_ch.ready) |-> !in_ch.ready, "input taken during output stall")

  // marks read clear right after reset
  `TTD_ASSERT_ALWAYS(a_marks_reset, clk, !$past(rst_n) |-> (out_ch.touched_marks == '0), "marks not cleared by reset")

endmodule
